// ----- rtl/core/disparity_to_point_reprojection_macros.svh -----
// assertion macros shared by the rtl
`ifndef DISPARITY_TO_POINT_REPROJECTION_MACROS_SVH
`define DISPARITY_TO_POINT_REPROJECTION_MACROS_SVH

// same-cycle implication
`define DPR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define DPR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/core/dpr_pkg.sv -----
package dpr_pkg;

  localparam int unsigned QBITS = 33;  // quotient bits produced by the divider
  localparam int unsigned NW    = 34;  // signed numerator width (q16.16)
  localparam int unsigned WW    = 41;  // signed denominator width (q8.24)
  localparam int unsigned RW    = 42;  // partial remainder width
  localparam int unsigned NDIV  = QBITS;

  typedef enum logic [2:0] {
    REG_OFFSET_X     = 3'd0,
    REG_OFFSET_Y     = 3'd1,
    REG_FOCAL_LENGTH = 3'd2,
    REG_INV_BASELINE = 3'd3,
    REG_CENTER_SHIFT = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [RW-1:0]    rem;
    logic [QBITS-1:0] lo;
    logic [QBITS-1:0] quo;
    logic             numneg;
    logic             nzero;
    logic             ovf;
  } lane_t;

  typedef struct packed {
    logic            valid;
    logic [WW-1:0]   wmag;
    logic            wneg;
    logic            wzero;
    logic [23:0]     color;
    lane_t [2:0]     lanes;
  } div_t;

endpackage

// ----- rtl/core/disparity_to_point_reprojection.sv -----
// Reprojects one stereo pixel per clock into a signed q16.16 point
// (x, y, z) with packed 0xRRGGBB color. An item is taken whenever start_i is
// high; busy_o is always low, so a new pixel may enter every cycle. Pixels
// with zero disparity or outside MAX_COLUMNS x MAX_ROWS give no result. A
// result appears on done_o for exactly one cycle; the receiver cannot stall,
// so nothing in the pipeline ever waits. The pipeline is the restoring
// divider, one quotient bit per stage over 33 stages, with three lanes
// (x, y, z) sharing each stage's w, plus the input, w/numerator, seed and
// output registers. When w is zero or a quotient does not fit in 32 bits the
// coordinate saturates (a zero numerator over zero w gives 0) and
// overflow_flag_o is set. The user must write registers through cfg_we_i only
// while the pipeline is empty; the block itself does not enforce it.
`include "disparity_to_point_reprojection_macros.svh"

module disparity_to_point_reprojection #(
  parameter int MAX_COLUMNS = 4096,
  parameter int MAX_ROWS    = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [7:0]         disparity_i,
  input  logic [7:0]         blue_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         red_i,
  input  logic [11:0]        column_i,
  input  logic [11:0]        row_i,
  output logic               done_o,
  output logic signed [31:0] point_x_o,
  output logic signed [31:0] point_y_o,
  output logic signed [31:0] point_z_o,
  output logic [23:0]        packed_color_o,
  output logic               overflow_flag_o
);
  import dpr_pkg::*;

  // configuration registers
  logic signed [31:0] offset_x_q, offset_y_q, focal_q, inv_base_q, shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_x_q <= '0;
      offset_y_q <= '0;
      focal_q    <= 32'sd65536;
      inv_base_q <= 32'sd16777216;
      shift_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_OFFSET_X:     offset_x_q <= cfg_wdata_i;
        REG_OFFSET_Y:     offset_y_q <= cfg_wdata_i;
        REG_FOCAL_LENGTH: focal_q    <= cfg_wdata_i;
        REG_INV_BASELINE: inv_base_q <= cfg_wdata_i;
        REG_CENTER_SHIFT: shift_q    <= cfg_wdata_i;
        default:          ;  // index beyond the list is dropped
      endcase
    end
  end

  assign busy_o = 1'b0;

  // stage 0: input register, drop pixels that give no result
  logic        s0_valid_q;
  logic [7:0]  s0_disp_q;
  logic [11:0] s0_col_q, s0_row_q;
  logic [23:0] s0_color_q;
  logic        in_keep;

  assign in_keep = start_i && (disparity_i != 8'd0)
                   && (32'(column_i) < MAX_COLUMNS) && (32'(row_i) < MAX_ROWS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s0_valid_q <= 1'b0;
    else         s0_valid_q <= in_keep;
  end

  always_ff @(posedge clk_i) begin
    s0_disp_q  <= disparity_i;
    s0_col_q   <= column_i;
    s0_row_q   <= row_i;
    s0_color_q <= {red_i, green_i, blue_i};
  end

  // stage 1: w = d*inverse_baseline + shift, numerators in q16.16
  logic                 s1_valid_q;
  logic signed [WW-1:0] s1_w_q;
  logic signed [NW-1:0] s1_num_q [3];
  logic [23:0]          s1_color_q;
  logic signed [WW-1:0] w_prod;

  assign w_prod = WW'($signed({1'b0, s0_disp_q}) * inv_base_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_valid_q <= 1'b0;
    else         s1_valid_q <= s0_valid_q;
  end

  always_ff @(posedge clk_i) begin
    s1_w_q      <= w_prod + WW'(shift_q);
    s1_num_q[0] <= $signed({(NW-28)'(0), s0_col_q, 16'd0}) + NW'(offset_x_q);
    s1_num_q[1] <= $signed({(NW-28)'(0), s0_row_q, 16'd0}) + NW'(offset_y_q);
    s1_num_q[2] <= NW'(focal_q);
    s1_color_q  <= s0_color_q;
  end

  // stage 2: magnitudes and divider seed
  div_t div_q [NDIV+1];
  div_t seed_d;

  always_comb begin
    logic [WW-1:0]       wm;
    logic [NW-1:0]       nm;
    logic [NW+24-1:0]    nn;
    logic [NW+24-1-QBITS:0] hi;
    wm = s1_w_q[WW-1] ? WW'(-s1_w_q) : WW'(s1_w_q);
    seed_d       = '0;
    seed_d.valid = s1_valid_q;
    seed_d.wmag  = wm;
    seed_d.wneg  = s1_w_q[WW-1];
    seed_d.wzero = (s1_w_q == '0);
    seed_d.color = s1_color_q;
    for (int l = 0; l < 3; l++) begin
      nm = s1_num_q[l][NW-1] ? NW'(-s1_num_q[l]) : NW'(s1_num_q[l]);
      nn = {nm, 24'd0};
      hi = nn[NW+24-1:QBITS];
      seed_d.lanes[l].rem    = RW'(hi);
      seed_d.lanes[l].lo     = nn[QBITS-1:0];
      seed_d.lanes[l].quo    = '0;
      seed_d.lanes[l].numneg = s1_num_q[l][NW-1];
      seed_d.lanes[l].nzero  = (s1_num_q[l] == '0);
      // quotient would need more than QBITS bits
      seed_d.lanes[l].ovf    = (RW'(hi) >= RW'(wm));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) div_q[0] <= '0;
    else         div_q[0] <= seed_d;
  end

  // divider stages: one quotient bit per stage per lane
  for (genvar s = 0; s < NDIV; s++) begin : g_div
    div_t step_d;

    always_comb begin
      logic [RW-1:0] t;
      step_d = div_q[s];
      for (int l = 0; l < 3; l++) begin
        t = {div_q[s].lanes[l].rem[RW-2:0], div_q[s].lanes[l].lo[QBITS-1]};
        step_d.lanes[l].lo = {div_q[s].lanes[l].lo[QBITS-2:0], 1'b0};
        if (t >= RW'(div_q[s].wmag)) begin
          step_d.lanes[l].rem = t - RW'(div_q[s].wmag);
          step_d.lanes[l].quo = {div_q[s].lanes[l].quo[QBITS-2:0], 1'b1};
        end else begin
          step_d.lanes[l].rem = t;
          step_d.lanes[l].quo = {div_q[s].lanes[l].quo[QBITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) div_q[s+1] <= '0;
      else         div_q[s+1] <= step_d;
    end
  end

  // final stage: sign, saturation and flag
  div_t        fin;
  logic [31:0] pt_d [3];
  logic        flag_d;
  logic        done_q, flag_q;
  logic [31:0] pt_q [3];
  logic [23:0] color_q;

  assign fin = div_q[NDIV];

  always_comb begin
    logic neg;
    flag_d = fin.wzero;
    for (int l = 0; l < 3; l++) begin
      neg = fin.lanes[l].numneg ^ fin.wneg;
      if (fin.wzero) begin
        // zero w: saturate by numerator sign
        if (fin.lanes[l].nzero)       pt_d[l] = 32'h0000_0000;
        else if (fin.lanes[l].numneg) pt_d[l] = 32'h8000_0000;
        else                          pt_d[l] = 32'h7FFF_FFFF;
      end else if (neg) begin
        if (fin.lanes[l].ovf || (fin.lanes[l].quo > QBITS'(33'h0_8000_0000))) begin
          pt_d[l] = 32'h8000_0000;
          flag_d  = 1'b1;
        end else begin
          pt_d[l] = 32'(-fin.lanes[l].quo[31:0]);
        end
      end else begin
        if (fin.lanes[l].ovf || (fin.lanes[l].quo > QBITS'(33'h0_7FFF_FFFF))) begin
          pt_d[l] = 32'h7FFF_FFFF;
          flag_d  = 1'b1;
        end else begin
          pt_d[l] = fin.lanes[l].quo[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= fin.valid;
  end

  always_ff @(posedge clk_i) begin
    pt_q[0] <= pt_d[0];
    pt_q[1] <= pt_d[1];
    pt_q[2] <= pt_d[2];
    color_q <= fin.color;
    flag_q  <= flag_d;
  end

  assign done_o          = done_q;
  assign point_x_o       = pt_q[0];
  assign point_y_o       = pt_q[1];
  assign point_z_o       = pt_q[2];
  assign packed_color_o  = color_q;
  assign overflow_flag_o = flag_q;

  // pipeline never holds an item back
  `DPR_ASSERT_NEXT(a_s1_to_div, s1_valid_q, div_q[0].valid)
  // zero w always raises the flag on its result
  `DPR_ASSERT_NEXT(a_wzero_flag, fin.valid && fin.wzero, done_o && overflow_flag_o)
  // every result strobe comes from the last divider stage
  `DPR_ASSERT_NEXT(a_done_src, !fin.valid, !done_o)
  // an offered item is never turned away
  `DPR_ASSERT_NOW(a_busy_low, start_i, !busy_o)

endmodule
